### sv/rgb_led_strip_refresher_defines.svh
// Assertion helpers for the top-level file, which carries the concurrent checks.
// Both forms sample on the rising edge of clock and are disabled in reset.
`ifndef RGB_LED_STRIP_REFRESHER_DEFINES_SVH
`define RGB_LED_STRIP_REFRESHER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLSR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rlsr check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define RLSR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rlsr check failed one cycle later");

`endif

### sv/rlsr_pkg.sv
package rlsr_pkg;

   localparam int WORD_W     = 24;
   localparam int PIXEL_BITS = 24;

   localparam logic [7:0]  ONE_HIGH_RST   = 8'd16;
   localparam logic [7:0]  ZERO_HIGH_RST  = 8'd8;
   localparam logic [7:0]  BIT_PERIOD_RST = 8'd25;
   localparam logic [15:0] LATCH_RST      = 16'd1000;
   localparam logic [23:0] LEAD_RST       = 24'd0;
   localparam logic [8:0]  LED_COUNT_RST  = 9'd256;

   typedef enum logic [1:0] {
      ACT_TICK    = 2'd0,
      ACT_FILL    = 2'd1,
      ACT_REFRESH = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      CSR_ONE_HIGH   = 3'd0,
      CSR_ZERO_HIGH  = 3'd1,
      CSR_BIT_PERIOD = 3'd2,
      CSR_LATCH      = 3'd3,
      CSR_LEAD_WORD  = 3'd4,
      CSR_LED_COUNT  = 3'd5
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;       // refresh accepted: load the lead word, clear counters
      logic fill_start;  // fill accepted: load the write range and color
      logic tick_send;   // tick accepted during a frame
      logic tick_latch;  // tick accepted during the latch gap
      logic wr_step;     // write one store entry (clear pass or fill)
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic level;       // line level for the current tick while sending
      logic frame_end;   // this tick ends the last bit of the last word
      logic latch_done;  // this tick ends the latch gap
      logic wr_last;     // the write pointer is at the last entry of its range
   } status_type;

endpackage

### sv/rgb_led_strip_refresher.sv
// Refresher for a single-wire RGB LED strip with a store of MAX_PIXELS colors.
// Request beats carry an action (tick, fill, refresh), a fill range and a color.
// Every accepted request beat yields exactly one response beat with the data
// line level and a busy flag; the response is registered and appears in the cycle after acceptance.
// A tick, or any beat during a frame, completes without holding off the next beat, so ticks can be fed every
// cycle while no waiting response is held by rsp_stall. A fill writes one entry at a time, because the store has
// a single write port; req_stall stays high until the last entry is written.
// A refresh fetches pixels from the store one word ahead, on the read port.
// After reset the store is cleared to black by a pass over all MAX_PIXELS entries,
// during which req_stall is high; configuration writes are taken at any time.
// The response sits in an output register. While rsp_stall holds it, no
// request beat can complete until that register is free, so
// req_stall follows rsp_stall when a response is waiting.
// Configuration is written through csr_valid/csr_ready with a register index;
// csr_ready is always high and writes are expected only while the block is idle.
module rgb_led_strip_refresher
   import rlsr_pkg::*;
#(
   parameter int MAX_PIXELS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_first_index,
   input  logic [7:0]  req_last_index,
   input  logic [23:0] req_color,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_data_line,
   output logic        rsp_busy_res,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

`include "rgb_led_strip_refresher_defines.svh"

   cmd_type    cmd;
   status_type status;

   // Registers are plain flops, so every write beat is taken at once.
   assign csr_ready = 1'b1;

   // The controller owns the handshakes, the phase and the response register.
   rlsr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data_line (rsp_data_line),
      .rsp_busy_res  (rsp_busy_res),
      .status        (status),
      .cmd           (cmd)
   );

   // The datapath holds the registers, pulse counters, shifter and pixel store.
   rlsr_datapath #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_first_index (req_first_index),
      .req_last_index  (req_last_index),
      .req_color       (req_color),
      .cmd             (cmd),
      .status          (status)
   );

   // The controller never issues two datapath commands in one cycle.
   `RLSR_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(cmd))
   // An accepted fill holds off the next request while the store is written.
   `RLSR_ASSERT_NEXT(a_fill_stalls, cmd.fill_start, req_stall)
   // The clearing pass runs right after reset, so no request is taken then.
   `RLSR_ASSERT_SAME(a_clear_stalls, $past(reset), req_stall)
   // A high line level only ever comes with a busy response.
   `RLSR_ASSERT_SAME(a_line_busy, rsp_valid && rsp_data_line, rsp_busy_res)

endmodule

### sv/rlsr_ram.sv
module rlsr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/rlsr_datapath.sv
module rlsr_datapath
   import rlsr_pkg::*;
#(
   parameter int MAX_PIXELS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [23:0]       csr_wdata,
   input  logic [7:0]        req_first_index,
   input  logic [7:0]        req_last_index,
   input  logic [23:0]       req_color,
   input  cmd_type           cmd,
   output status_type        status
);

   localparam int AW   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int WC_W = ($clog2(MAX_PIXELS + 2) > 9) ? $clog2(MAX_PIXELS + 2) : 9;
   localparam int CW   = (AW > 8) ? AW : 8;

   localparam logic [WC_W-1:0] MAX_WC  = WC_W'(MAX_PIXELS);
   localparam logic [CW-1:0]   MAX_IDX = CW'(MAX_PIXELS - 1);

   logic [7:0]        one_high_ff,   one_high_in;
   logic [7:0]        zero_high_ff,  zero_high_in;
   logic [7:0]        bit_period_ff, bit_period_in;
   logic [15:0]       latch_ticks_ff, latch_ticks_in;
   logic [23:0]       lead_word_ff,  lead_word_in;
   logic [8:0]        led_count_ff,  led_count_in;

   logic [23:0]       shift_ff, shift_in;
   logic [7:0]        tick_ff,  tick_in;
   logic [4:0]        bit_ff,   bit_in;
   logic [WC_W-1:0]   word_ff,  word_in;
   logic [15:0]       latch_ff, latch_in;
   logic              rd_pending_ff, rd_pending_in;

   logic [AW-1:0]     wr_ptr_ff,  wr_ptr_in;
   logic [AW-1:0]     wr_end_ff,  wr_end_in;
   logic [23:0]       wr_data_ff, wr_data_in;

   logic [7:0]        period_eff;
   logic [7:0]        high_time;
   logic              bit_end;
   logic              bit_last;
   logic [WC_W-1:0]   word_next;
   logic [WC_W-1:0]   led_ext;
   logic [WC_W-1:0]   pixels_per_frame;
   logic [15:0]       latch_next;
   logic [CW-1:0]     lo_ext;
   logic [CW-1:0]     hi_ext;
   logic [23:0]       rd_data;
   logic              rd_en;

   // Pulse timing decode.
   assign period_eff = (bit_period_ff == 8'd0) ? 8'd1 : bit_period_ff;
   assign high_time  = shift_ff[WORD_W-1] ? one_high_ff : zero_high_ff;
   assign bit_end    = ({1'b0, tick_ff} + 9'd1) >= {1'b0, period_eff};
   assign bit_last   = bit_ff == 5'(PIXEL_BITS - 1);
   assign word_next  = word_ff + WC_W'(1);
   assign led_ext    = WC_W'(led_count_ff);
   assign pixels_per_frame = (led_ext > MAX_WC) ? MAX_WC : led_ext;
   assign latch_next = latch_ff + 16'd1;

   assign status.level      = tick_ff < high_time;
   assign status.frame_end  = bit_end && bit_last && (word_next > pixels_per_frame);
   assign status.latch_done = (latch_next >= latch_ticks_ff) || (latch_next == 16'd0);
   assign status.wr_last    = wr_ptr_ff == wr_end_ff;

   // Fill range: order the ends, then clamp them to the store.
   always_comb begin
      lo_ext = (req_first_index > req_last_index) ? CW'(req_last_index) : CW'(req_first_index);
      hi_ext = (req_first_index > req_last_index) ? CW'(req_first_index) : CW'(req_last_index);
      if (lo_ext > MAX_IDX) begin
         lo_ext = MAX_IDX;
      end
      if (hi_ext > MAX_IDX) begin
         hi_ext = MAX_IDX;
      end
   end

   always_comb begin
      one_high_in    = one_high_ff;
      zero_high_in   = zero_high_ff;
      bit_period_in  = bit_period_ff;
      latch_ticks_in = latch_ticks_ff;
      lead_word_in   = lead_word_ff;
      led_count_in   = led_count_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ONE_HIGH:   one_high_in    = csr_wdata[7:0];
            CSR_ZERO_HIGH:  zero_high_in   = csr_wdata[7:0];
            CSR_BIT_PERIOD: bit_period_in  = csr_wdata[7:0];
            CSR_LATCH:      latch_ticks_in = csr_wdata[15:0];
            CSR_LEAD_WORD:  lead_word_in   = csr_wdata;
            CSR_LED_COUNT:  led_count_in   = csr_wdata[8:0];
            default:        ;
         endcase
      end
   end

   always_comb begin
      shift_in      = shift_ff;
      tick_in       = tick_ff;
      bit_in        = bit_ff;
      word_in       = word_ff;
      latch_in      = latch_ff;
      rd_pending_in = 1'b0;
      if (cmd.start) begin
         shift_in      = lead_word_ff;
         tick_in       = 8'd0;
         bit_in        = 5'd0;
         word_in       = '0;
         latch_in      = 16'd0;
         rd_pending_in = 1'b1;
      end else if (cmd.tick_send) begin
         if (!bit_end) begin
            tick_in = tick_ff + 8'd1;
         end else begin
            tick_in  = 8'd0;
            shift_in = {shift_ff[WORD_W-2:0], 1'b0};
            if (!bit_last) begin
               bit_in = bit_ff + 5'd1;
            end else begin
               bit_in  = 5'd0;
               word_in = word_next;
               if (status.frame_end) begin
                  latch_in = 16'd0;
               end else begin
                  // The next pixel was fetched when this word was loaded.
                  shift_in      = rd_data;
                  rd_pending_in = 1'b1;
               end
            end
         end
      end else if (cmd.tick_latch) begin
         latch_in = latch_next;
      end
   end

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      wr_end_in  = wr_end_ff;
      wr_data_in = wr_data_ff;
      if (cmd.fill_start) begin
         wr_ptr_in  = AW'(lo_ext);
         wr_end_in  = AW'(hi_ext);
         wr_data_in = req_color;
      end else if (cmd.wr_step && !status.wr_last) begin
         wr_ptr_in = wr_ptr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         one_high_ff    <= ONE_HIGH_RST;
         zero_high_ff   <= ZERO_HIGH_RST;
         bit_period_ff  <= BIT_PERIOD_RST;
         latch_ticks_ff <= LATCH_RST;
         lead_word_ff   <= LEAD_RST;
         led_count_ff   <= LED_COUNT_RST;
         shift_ff       <= '0;
         tick_ff        <= '0;
         bit_ff         <= '0;
         word_ff        <= '0;
         latch_ff       <= '0;
         rd_pending_ff  <= 1'b0;
         wr_ptr_ff      <= '0;
         wr_end_ff      <= AW'(MAX_PIXELS - 1);
         wr_data_ff     <= '0;
      end else begin
         one_high_ff    <= one_high_in;
         zero_high_ff   <= zero_high_in;
         bit_period_ff  <= bit_period_in;
         latch_ticks_ff <= latch_ticks_in;
         lead_word_ff   <= lead_word_in;
         led_count_ff   <= led_count_in;
         shift_ff       <= shift_in;
         tick_ff        <= tick_in;
         bit_ff         <= bit_in;
         word_ff        <= word_in;
         latch_ff       <= latch_in;
         rd_pending_ff  <= rd_pending_in;
         wr_ptr_ff      <= wr_ptr_in;
         wr_end_ff      <= wr_end_in;
         wr_data_ff     <= wr_data_in;
      end
   end

   // Prefetch the pixel for the next word boundary; word_ff is its index here.
   assign rd_en = rd_pending_ff && (word_ff < MAX_WC);

   rlsr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.wr_step),
      .wr_addr (wr_ptr_ff),
      .wr_data (wr_data_ff),
      .rd_en   (rd_en),
      .rd_addr (word_ff[AW-1:0]),
      .rd_data (rd_data)
   );

endmodule

### sv/rlsr_ctrl.sv
module rlsr_ctrl
   import rlsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_data_line,
   output logic        rsp_busy_res,
   input  status_type  status,
   output cmd_type     cmd
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_FILL  = 5'b00100,
      ST_SEND  = 5'b01000,
      ST_LATCH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_line_ff,  rsp_line_in;
   logic      rsp_busy_ff,  rsp_busy_in;
   logic      out_free;
   logic      take;
   logic      in_frame;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_frame  = (state_ff == ST_SEND) || (state_ff == ST_LATCH);
   assign req_stall = !((state_ff == ST_IDLE) || in_frame) || !out_free;
   assign take      = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR, ST_FILL: begin
            cmd.wr_step = 1'b1;
            if (status.wr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               case (req_action)
                  ACT_FILL: begin
                     cmd.fill_start = 1'b1;
                     state_in       = ST_FILL;
                  end
                  ACT_REFRESH: begin
                     cmd.start = 1'b1;
                     state_in  = ST_SEND;
                  end
                  default: ;
               endcase
            end
         end
         ST_SEND: begin
            if (take && (req_action == ACT_TICK)) begin
               cmd.tick_send = 1'b1;
               if (status.frame_end) begin
                  state_in = ST_LATCH;
               end
            end
         end
         ST_LATCH: begin
            if (take && (req_action == ACT_TICK)) begin
               cmd.tick_latch = 1'b1;
               if (status.latch_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_busy_in  = rsp_busy_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_line_in  = (state_ff == ST_SEND) && status.level;
         rsp_busy_in  = in_frame || (req_action == ACT_REFRESH);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_line_ff <= rsp_line_in;
      rsp_busy_ff <= rsp_busy_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_line = rsp_line_ff;
   assign rsp_busy_res  = rsp_busy_ff;

endmodule
